// ===== sv/tccb_pkg.sv =====
// ============================================================================
// tccb_pkg
// Shared types and constants of the text console cell buffer: cell layout,
// control characters, register indexes and reset values.
// ============================================================================
package tccb_pkg;

    // Default grid size
    localparam int TEXT_ROWS_DEF = 45;
    localparam int TEXT_COLS_DEF = 160;

    // Field widths fixed by the interface
    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // One screen cell
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CHAR_W-1:0]  chr;
    } cell_t;

    localparam logic [COLOR_W-1:0] WHITE_IDX  = 3'd6;
    localparam cell_t              BLANK_CELL = '{color: WHITE_IDX, chr: 8'd0};

    // Control characters
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    // Item function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRAW_COLOR   = 2'd0,
        CFG_CURSOR_GLYPH = 2'd1,
        CFG_LINE_WIDTH   = 2'd2
    } cfg_index_t;

    // Register reset values
    localparam logic [COLOR_W-1:0] DRAW_COLOR_RST   = WHITE_IDX;
    localparam logic [CHAR_W-1:0]  CURSOR_GLYPH_RST = 8'd128;
    localparam logic [COL_W-1:0]   LINE_WIDTH_RST   = 8'd80;

endpackage

// ===== sv/tccb_cell_mem.sv =====
// ============================================================================
// tccb_cell_mem
// Simple dual-port cell RAM: one write port, one read port with registered
// read data.
// ============================================================================
module tccb_cell_mem #(
    parameter int DEPTH = tccb_pkg::TEXT_ROWS_DEF * tccb_pkg::TEXT_COLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  tccb_pkg::cell_t      wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output tccb_pkg::cell_t      rd_data
);

    tccb_pkg::cell_t mem_array [DEPTH];
    tccb_pkg::cell_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tccb_sweep.sv =====
// ============================================================================
// tccb_sweep
// Whole-grid sweep engine: clears every cell after reset, and on request
// moves every row up one and blanks the bottom row, one cell per cycle.
// ============================================================================
module tccb_sweep #(
    parameter int TEXT_ROWS = tccb_pkg::TEXT_ROWS_DEF,
    parameter int TEXT_COLS = tccb_pkg::TEXT_COLS_DEF,
    parameter int AW        = $clog2(TEXT_ROWS * TEXT_COLS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    output logic                 busy,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  tccb_pkg::cell_t      rd_data,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output tccb_pkg::cell_t      wr_data
);

    localparam int DEPTH  = TEXT_ROWS * TEXT_COLS;
    localparam int COPY_N = (TEXT_ROWS - 1) * TEXT_COLS;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW-1:0] COPY_LIM = AW'(COPY_N);
    localparam logic [AW-1:0] ROW_STEP = AW'(TEXT_COLS);

    // Read stage
    logic          active_reg, active_next;
    logic          copy_mode_reg, copy_mode_next;
    logic [AW-1:0] idx_reg, idx_next;
    // Write stage
    logic          wb_valid_reg, wb_valid_next;
    logic          wb_copy_reg, wb_copy_next;
    logic [AW-1:0] wb_addr_reg, wb_addr_next;

    always_comb begin
        active_next    = active_reg;
        copy_mode_next = copy_mode_reg;
        idx_next       = idx_reg;
        wb_valid_next  = active_reg;
        wb_addr_next   = idx_reg;
        wb_copy_next   = copy_mode_reg && (idx_reg < COPY_LIM);
        if (active_reg) begin
            if (idx_reg == LAST_IDX) begin
                active_next = 1'b0;
                idx_next    = '0;
            end else begin
                idx_next = idx_reg + AW'(1);
            end
        end else if (start) begin
            active_next    = 1'b1;
            copy_mode_next = 1'b1;
            idx_next       = '0;
        end
    end

    // Reset starts a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b1;
            copy_mode_reg <= 1'b0;
            idx_reg       <= '0;
            wb_valid_reg  <= 1'b0;
        end else begin
            active_reg    <= active_next;
            copy_mode_reg <= copy_mode_next;
            idx_reg       <= idx_next;
            wb_valid_reg  <= wb_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_copy_reg <= wb_copy_next;
        wb_addr_reg <= wb_addr_next;
    end

    // Source cell lies one row below the destination; bottom row needs no read
    assign rd_en   = active_reg && copy_mode_reg && (idx_reg < COPY_LIM);
    assign rd_addr = idx_reg + ROW_STEP;
    assign wr_en   = wb_valid_reg;
    assign wr_addr = wb_addr_reg;
    assign wr_data = wb_copy_reg ? rd_data : tccb_pkg::BLANK_CELL;
    assign busy    = active_reg || wb_valid_reg;

endmodule

// ===== sv/text_console_cell_buffer_top.sv =====
// ============================================================================
// text_console_cell_buffer_top
// Text console cell store with cursor, line wrap and scroll.
// ============================================================================
// Input channel s_*: one item per handshake. s_func = put selects a character
// put (cursor erase, character, wrap/scroll, cursor glyph); read returns the
// cell at s_read_row/s_read_col. Every item yields exactly one result item on
// m_*, with the cursor position after the item.
// Item flow: a put or read goes from acceptance to the result register through
// accept/first write, glyph write or RAM read, and result load; one item is in
// work at a time, so the next item is accepted only once the last has moved on
// to the result register. A put that scrolls adds a grid sweep: the sweep engine
// moves the grid up one cell per cycle through the single RAM read/write port pair.
// Reset: after aresetn is released the sweep engine clears all
// TEXT_ROWS*TEXT_COLS cells, one per cycle; s_ready stays low until it ends.
// Configuration writes are taken in any cycle.
// Stall: the result register holds a finished item while m_ready is low; the
// next item is still accepted and worked, then waits until the register frees.
// ============================================================================
module text_console_cell_buffer_top #(
    parameter int TEXT_ROWS = tccb_pkg::TEXT_ROWS_DEF,
    parameter int TEXT_COLS = tccb_pkg::TEXT_COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration
    input  logic                               cfg_wr_en,
    input  logic [tccb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tccb_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [tccb_pkg::CHAR_W-1:0]        s_char_code,
    input  logic [tccb_pkg::ROW_W-1:0]         s_read_row,
    input  logic [tccb_pkg::COL_W-1:0]         s_read_col,
    // Result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tccb_pkg::ROW_W-1:0]         m_cursor_row,
    output logic [tccb_pkg::COL_W-1:0]         m_cursor_col,
    output logic                               m_scrolled,
    output logic [tccb_pkg::CHAR_W-1:0]        m_cell_char,
    output logic [tccb_pkg::COLOR_W-1:0]       m_cell_color
);

    localparam int DEPTH = TEXT_ROWS * TEXT_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [tccb_pkg::ROW_W:0]   ROWS_LIM = 7'(TEXT_ROWS);
    localparam logic [tccb_pkg::COL_W:0]   COLS_LIM = 9'(TEXT_COLS);
    localparam logic [tccb_pkg::ROW_W-1:0] LAST_ROW = 6'(TEXT_ROWS - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_GLYPH  = 6'b000100,
        S_SCROLL = 6'b001000,
        S_READ   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [tccb_pkg::ROW_W-1:0] r,
                                                input logic [tccb_pkg::COL_W-1:0] c);
        return AW'(AW'(r) * AW'(TEXT_COLS)) + AW'(c);
    endfunction

    state_t state_reg, state_next;

    // Cursor and configuration
    logic [tccb_pkg::ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [tccb_pkg::COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [tccb_pkg::COLOR_W-1:0] draw_color_reg, draw_color_next;
    logic [tccb_pkg::CHAR_W-1:0]  cursor_glyph_reg, cursor_glyph_next;
    logic [tccb_pkg::COL_W-1:0]   line_width_reg, line_width_next;

    // Item in work
    logic            scrolled_reg, scrolled_next;
    logic            rd_ok_reg, rd_ok_next;
    tccb_pkg::cell_t res_cell_reg, res_cell_next;

    // Result register
    logic                         m_valid_reg, m_valid_next;
    logic [tccb_pkg::ROW_W-1:0]   m_row_reg, m_row_next;
    logic [tccb_pkg::COL_W-1:0]   m_col_reg, m_col_next;
    logic                         m_scrolled_reg, m_scrolled_next;
    tccb_pkg::cell_t              m_cell_reg, m_cell_next;

    // Memory access
    logic            ctl_wr_en, ctl_rd_en;
    logic [AW-1:0]   ctl_wr_addr, ctl_rd_addr;
    tccb_pkg::cell_t ctl_wr_data;
    logic            sw_start, sw_busy, sw_rd_en, sw_wr_en;
    logic [AW-1:0]   sw_rd_addr, sw_wr_addr;
    tccb_pkg::cell_t sw_wr_data;
    logic            mem_wr_en, mem_rd_en;
    logic [AW-1:0]   mem_wr_addr, mem_rd_addr;
    tccb_pkg::cell_t mem_wr_data, mem_rd_data;

    // Put decode and cursor movement
    logic                        is_cr, is_lf, is_bs, is_print;
    logic [tccb_pkg::COL_W:0]    col_inc, wrap_col;
    logic                        wrap_hit, move_down, put_scroll, in_range;
    logic [tccb_pkg::ROW_W-1:0]  put_row;
    logic [tccb_pkg::COL_W-1:0]  put_col;

    always_comb begin
        is_cr     = (s_char_code == tccb_pkg::CH_RETURN);
        is_lf     = (s_char_code == tccb_pkg::CH_LINEFEED);
        is_bs     = (s_char_code == tccb_pkg::CH_BACKSPACE);
        is_print  = !(is_cr || is_lf || is_bs);
        col_inc   = {1'b0, cur_col_reg} + 9'd1;
        wrap_col  = ({1'b0, line_width_reg} < COLS_LIM) ? {1'b0, line_width_reg} : COLS_LIM;
        wrap_hit  = is_print && (col_inc >= wrap_col);
        move_down = is_lf || wrap_hit;
        put_scroll = move_down && (cur_row_reg == LAST_ROW);
        put_row   = (move_down && !put_scroll) ? cur_row_reg + 6'd1 : cur_row_reg;
        priority if (is_cr) begin
            put_col = '0;
        end else if (is_lf) begin
            put_col = cur_col_reg;
        end else if (is_bs) begin
            put_col = (cur_col_reg != '0) ? cur_col_reg - 8'd1 : cur_col_reg;
        end else begin
            put_col = wrap_hit ? '0 : col_inc[tccb_pkg::COL_W-1:0];
        end
        in_range = ({1'b0, s_read_row} < ROWS_LIM) && ({1'b0, s_read_col} < COLS_LIM);
    end

    // Configuration writes
    always_comb begin
        draw_color_next   = draw_color_reg;
        cursor_glyph_next = cursor_glyph_reg;
        line_width_next   = line_width_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tccb_pkg::CFG_DRAW_COLOR:   draw_color_next   = cfg_wr_data[tccb_pkg::COLOR_W-1:0];
                tccb_pkg::CFG_CURSOR_GLYPH: cursor_glyph_next = cfg_wr_data;
                tccb_pkg::CFG_LINE_WIDTH:   line_width_next   = cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Item sequencer
    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        scrolled_next   = scrolled_reg;
        rd_ok_next      = rd_ok_reg;
        res_cell_next   = res_cell_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_scrolled_next = m_scrolled_reg;
        m_cell_next     = m_cell_reg;
        ctl_wr_en       = 1'b0;
        ctl_wr_addr     = cell_addr(cur_row_reg, cur_col_reg);
        ctl_wr_data     = tccb_pkg::BLANK_CELL;
        ctl_rd_en       = 1'b0;
        ctl_rd_addr     = cell_addr(s_read_row, s_read_col);
        sw_start        = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                if (!sw_busy) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_func == tccb_pkg::FUNC_READ) begin
                        ctl_rd_en     = 1'b1;
                        rd_ok_next    = in_range;
                        scrolled_next = 1'b0;
                        state_next    = S_READ;
                    end else begin
                        // erase cursor cell, or store the character there
                        ctl_wr_en = 1'b1;
                        if (is_print) begin
                            ctl_wr_data = '{color: draw_color_reg, chr: s_char_code};
                        end
                        cur_row_next  = put_row;
                        cur_col_next  = put_col;
                        scrolled_next = put_scroll;
                        res_cell_next = '0;
                        sw_start      = put_scroll;
                        state_next    = put_scroll ? S_SCROLL : S_GLYPH;
                    end
                end
            end
            S_SCROLL: begin
                if (!sw_busy) begin
                    state_next = S_GLYPH;
                end
            end
            S_GLYPH: begin
                ctl_wr_en   = 1'b1;
                ctl_wr_data = '{color: draw_color_reg, chr: cursor_glyph_reg};
                state_next  = S_DONE;
            end
            S_READ: begin
                res_cell_next = rd_ok_reg ? mem_rd_data : '0;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_row_next      = cur_row_reg;
                    m_col_next      = cur_col_reg;
                    m_scrolled_next = scrolled_reg;
                    m_cell_next     = res_cell_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            draw_color_reg   <= tccb_pkg::DRAW_COLOR_RST;
            cursor_glyph_reg <= tccb_pkg::CURSOR_GLYPH_RST;
            line_width_reg   <= tccb_pkg::LINE_WIDTH_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            draw_color_reg   <= draw_color_next;
            cursor_glyph_reg <= cursor_glyph_next;
            line_width_reg   <= line_width_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scrolled_reg   <= scrolled_next;
        rd_ok_reg      <= rd_ok_next;
        res_cell_reg   <= res_cell_next;
        m_row_reg      <= m_row_next;
        m_col_reg      <= m_col_next;
        m_scrolled_reg <= m_scrolled_next;
        m_cell_reg     <= m_cell_next;
    end

    // RAM port sharing: the sweep engine owns the ports while busy
    assign mem_wr_en   = sw_wr_en || ctl_wr_en;
    assign mem_wr_addr = sw_wr_en ? sw_wr_addr : ctl_wr_addr;
    assign mem_wr_data = sw_wr_en ? sw_wr_data : ctl_wr_data;
    assign mem_rd_en   = sw_rd_en || ctl_rd_en;
    assign mem_rd_addr = sw_rd_en ? sw_rd_addr : ctl_rd_addr;

    tccb_sweep #(
        .TEXT_ROWS (TEXT_ROWS),
        .TEXT_COLS (TEXT_COLS),
        .AW        (AW)
    ) u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sw_start),
        .busy    (sw_busy),
        .rd_en   (sw_rd_en),
        .rd_addr (sw_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (sw_wr_en),
        .wr_addr (sw_wr_addr),
        .wr_data (sw_wr_data)
    );

    tccb_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cursor_col = m_col_reg;
    assign m_scrolled   = m_scrolled_reg;
    assign m_cell_char  = m_cell_reg.chr;
    assign m_cell_color = m_cell_reg.color;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No item is taken while the sweep engine owns the RAM
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sw_busy |-> !s_ready)
        else $error("item accepted during grid sweep");

    // Sweep and sequencer never write the RAM in the same cycle
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        sw_wr_en |-> !ctl_wr_en)
        else $error("RAM write port clash");

    // A put that scrolls starts the sweep right away
    a_scroll_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == tccb_pkg::FUNC_PUT) && put_scroll)
        |=> (sw_busy && (state_reg == S_SCROLL)))
        else $error("scroll did not start sweep");

    // Cursor stays on the grid
    a_cursor_on_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (({1'b0, cur_row_reg} < ROWS_LIM) && ({1'b0, cur_col_reg} < COLS_LIM)))
        else $error("cursor left the grid");

endmodule

// ===== dv/text_console_cell_buffer_top_test.sv =====
// ============================================================================
// text_console_cell_buffer_top_test
// Self-checking bench for the text console cell buffer. A scoreboard model of
// the screen grid and cursor predicts every result item. Directed tests cover
// the reset contents, control characters, reads outside the grid and the
// register corner cases. Random phases with random content then cover
// wrapping, scrolling and reads. Both channels stall at random.
// ============================================================================
module text_console_cell_buffer_top_test;

    localparam int ROW_W      = tccb_pkg::ROW_W;
    localparam int COL_W      = tccb_pkg::COL_W;
    localparam int CHAR_W     = tccb_pkg::CHAR_W;
    localparam int COLOR_W    = tccb_pkg::COLOR_W;
    localparam int CFG_IDX_W  = tccb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tccb_pkg::CFG_DATA_W;

    localparam int ROWS          = tccb_pkg::TEXT_ROWS_DEF;
    localparam int COLS          = tccb_pkg::TEXT_COLS_DEF;
    localparam int CELLS         = ROWS * COLS;
    localparam int SCROLL_BUDGET = 50;   // each scroll costs a full grid sweep
    localparam int END_SLACK     = 16;

    typedef tccb_pkg::cell_t cell_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               scrolled;
        logic [CHAR_W-1:0]  chr;
        logic [COLOR_W-1:0] color;
    } console_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [CHAR_W-1:0]     s_char_code;
    logic [ROW_W-1:0]      s_read_row;
    logic [COL_W-1:0]      s_read_col;
    logic                  m_valid;
    logic                  m_ready;
    logic [ROW_W-1:0]      m_cursor_row;
    logic [COL_W-1:0]      m_cursor_col;
    logic                  m_scrolled;
    logic [CHAR_W-1:0]     m_cell_char;
    logic [COLOR_W-1:0]    m_cell_color;

    // Screen model: grid, cursor and registers
    cell_t              screen [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] draw_color;
    logic [CHAR_W-1:0]  cursor_glyph;
    logic [COL_W-1:0]   line_width;

    console_result_t pending_results [$];

    int errors;
    int n_results;
    int n_puts;
    int n_reads;
    int n_outside;
    int n_scrolls;
    int n_settings;
    int send_idle_pct;
    int recv_idle_pct;

    text_console_cell_buffer_top #(
        .TEXT_ROWS(ROWS),
        .TEXT_COLS(COLS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cursor_row(m_cursor_row),
        .m_cursor_col(m_cursor_col),
        .m_scrolled  (m_scrolled),
        .m_cell_char (m_cell_char),
        .m_cell_color(m_cell_color)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("text_console_cell_buffer_top_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------
    function automatic void console_reset();
        int i;
        for (i = 0; i < CELLS; i++) screen[i] = tccb_pkg::BLANK_CELL;
        cur_row      = 0;
        cur_col      = 0;
        draw_color   = tccb_pkg::DRAW_COLOR_RST;
        cursor_glyph = tccb_pkg::CURSOR_GLYPH_RST;
        line_width   = tccb_pkg::LINE_WIDTH_RST;
    endfunction

    function automatic void store_cell(int r, int c, logic [COLOR_W-1:0] color,
                                       logic [CHAR_W-1:0] chr);
        if (r < ROWS && c < COLS) begin
            screen[r*COLS + c].color = color;
            screen[r*COLS + c].chr   = chr;
        end
    endfunction

    // Move every row up one and blank the bottom row
    function automatic void scroll_screen();
        int i;
        for (i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i + COLS];
        for (i = (ROWS-1)*COLS; i < CELLS; i++) screen[i] = tccb_pkg::BLANK_CELL;
    endfunction

    function automatic logic advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            scroll_screen();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one item to the model and return the result it should produce
    function automatic console_result_t console_apply(logic f, logic [CHAR_W-1:0] ch,
                                                      logic [ROW_W-1:0] rr,
                                                      logic [COL_W-1:0] rc);
        console_result_t res;
        int wrap;
        res = '0;
        if (f == tccb_pkg::FUNC_READ) begin
            if (int'(rr) < ROWS && int'(rc) < COLS) begin
                res.chr   = screen[int'(rr)*COLS + int'(rc)].chr;
                res.color = screen[int'(rr)*COLS + int'(rc)].color;
            end
        end else begin
            // widths above the grid wrap at the grid edge; zero acts as one
            wrap = (int'(line_width) < COLS) ? int'(line_width) : COLS;
            store_cell(cur_row, cur_col, tccb_pkg::BLANK_CELL.color,
                       tccb_pkg::BLANK_CELL.chr);
            if (ch == tccb_pkg::CH_RETURN) begin
                cur_col = 0;
            end else if (ch == tccb_pkg::CH_LINEFEED) begin
                res.scrolled = advance_row();
            end else if (ch == tccb_pkg::CH_BACKSPACE) begin
                if (cur_col > 0) begin
                    cur_col--;
                    store_cell(cur_row, cur_col, tccb_pkg::BLANK_CELL.color,
                               tccb_pkg::BLANK_CELL.chr);
                end
            end else begin
                store_cell(cur_row, cur_col, draw_color, ch);
                cur_col++;
                if (cur_col >= wrap) begin
                    cur_col      = 0;
                    res.scrolled = advance_row();
                end
            end
            store_cell(cur_row, cur_col, draw_color, cursor_glyph);
        end
        res.row = cur_row[ROW_W-1:0];
        res.col = cur_col[COL_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 n_results, what, got, want);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        console_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("item with nothing expected", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_cursor_row !== want.row)
                    report_mismatch("cursor_row", m_cursor_row, want.row);
                if (m_cursor_col !== want.col)
                    report_mismatch("cursor_col", m_cursor_col, want.col);
                if (m_scrolled !== want.scrolled)
                    report_mismatch("scrolled", m_scrolled, want.scrolled);
                if (m_cell_char !== want.chr)
                    report_mismatch("cell_char", m_cell_char, want.chr);
                if (m_cell_color !== want.color)
                    report_mismatch("cell_color", m_cell_color, want.color);
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Valid stays high across back-to-back items; it drops only on a gap
    task automatic send_item(logic f, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] rr,
                             logic [COL_W-1:0] rc);
        console_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_char_code <= ch;
        s_read_row  <= rr;
        s_read_col  <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = console_apply(f, ch, rr, rc);
        pending_results.push_back(res);
        if (f == tccb_pkg::FUNC_READ) begin
            n_reads++;
            if (int'(rr) >= ROWS || int'(rc) >= COLS) n_outside++;
        end else begin
            n_puts++;
            if (res.scrolled) n_scrolls++;
        end
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_item(tccb_pkg::FUNC_PUT, ch, ROW_W'($urandom_range(0, 63)),
                  COL_W'($urandom_range(0, 255)));
    endtask

    task automatic read_cell(int r, int c);
        send_item(tccb_pkg::FUNC_READ, CHAR_W'($urandom_range(0, 255)), ROW_W'(r),
                  COL_W'(c));
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(tccb_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tccb_pkg::CFG_DRAW_COLOR:   draw_color   = data[COLOR_W-1:0];
            tccb_pkg::CFG_CURSOR_GLYPH: cursor_glyph = data[CHAR_W-1:0];
            tccb_pkg::CFG_LINE_WIDTH:   line_width   = data[COL_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_random_item();
        logic              f;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        int                pick;
        int                wrap;
        pick = $urandom_range(0, 99);
        f    = tccb_pkg::FUNC_PUT;
        ch   = CHAR_W'($urandom_range(0, 255));
        rr   = ROW_W'($urandom_range(0, 63));
        rc   = COL_W'($urandom_range(0, 255));
        if (pick < 25) begin
            f = tccb_pkg::FUNC_READ;
            // mostly inside the grid, often on the cursor row
            if (pick < 20) begin
                rr = (pick < 10) ? ROW_W'(cur_row) : ROW_W'($urandom_range(0, ROWS - 1));
                rc = COL_W'($urandom_range(0, COLS - 1));
            end
        end else if (pick < 37) begin
            ch = tccb_pkg::CH_LINEFEED;
        end else if (pick < 45) begin
            ch = tccb_pkg::CH_RETURN;
        end else if (pick < 52) begin
            ch = tccb_pkg::CH_BACKSPACE;
        end
        // once enough scrolls are seen, a put that would scroll becomes a read
        wrap = (int'(line_width) < COLS) ? int'(line_width) : COLS;
        if (f == tccb_pkg::FUNC_PUT && n_scrolls >= SCROLL_BUDGET && cur_row == ROWS - 1 &&
            (ch == tccb_pkg::CH_LINEFEED ||
             (ch != tccb_pkg::CH_RETURN && ch != tccb_pkg::CH_BACKSPACE &&
              cur_col + 1 >= wrap)))
            f = tccb_pkg::FUNC_READ;
        send_item(f, ch, rr, rc);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Cleared grid, grid corners, and reads past either edge
    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        read_cell(63, 255);
    endtask

    // Printable extremes, return, line feed and both backspace cases
    task automatic test_control_chars();
        put_char(8'h41);
        read_cell(0, 0);
        read_cell(0, 1);
        put_char(8'hFF);
        put_char(tccb_pkg::CH_BACKSPACE);
        read_cell(0, 2);
        put_char(tccb_pkg::CH_RETURN);
        put_char(tccb_pkg::CH_BACKSPACE);      // at column 0: cursor only
        put_char(tccb_pkg::CH_LINEFEED);
        put_char(8'h00);
    endtask

    // Color 7, glyph extremes, zero width, wide width, width under the cursor
    task automatic test_register_cases();
        wait_results();
        write_reg(tccb_pkg::CFG_DRAW_COLOR, 8'hFF);
        write_reg(tccb_pkg::CFG_CURSOR_GLYPH, 8'hFF);
        write_reg(tccb_pkg::CFG_LINE_WIDTH, 8'd0);
        n_settings++;
        put_char(8'h78);
        read_cell(cur_row - 1, 1);
        read_cell(cur_row, 0);
        wait_results();
        write_reg(tccb_pkg::CFG_LINE_WIDTH, 8'd255);
        n_settings++;
        repeat (5) put_char(CHAR_W'($urandom_range(32, 126)));
        wait_results();
        write_reg(tccb_pkg::CFG_LINE_WIDTH, 8'd3);
        write_reg(tccb_pkg::CFG_DRAW_COLOR, 8'd0);
        write_reg(tccb_pkg::CFG_CURSOR_GLYPH, 8'd0);
        n_settings++;
        put_char(8'h7E);             // stored at column 5, then wraps
        read_cell(cur_row - 1, 5);
        read_cell(cur_row, 0);
    endtask

    task automatic test_random_phase(int n_items, logic [CFG_DATA_W-1:0] color,
                                     logic [CFG_DATA_W-1:0] glyph,
                                     logic [CFG_DATA_W-1:0] width);
        wait_results();
        write_reg(tccb_pkg::CFG_DRAW_COLOR, color);
        write_reg(tccb_pkg::CFG_CURSOR_GLYPH, glyph);
        write_reg(tccb_pkg::CFG_LINE_WIDTH, width);
        n_settings++;
        repeat (n_items) begin
            if ($urandom_range(0, 49) == 0) wait_results();
            send_random_item();
        end
    endtask

    // Line feeds until the screen has scrolled at least once
    task automatic test_scroll_at_bottom();
        while (n_scrolls == 0) begin
            if ($urandom_range(0, 3) == 0) read_cell($urandom_range(0, ROWS - 1),
                                                     $urandom_range(0, COLS - 1));
            put_char(tccb_pkg::CH_LINEFEED);
        end
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 2, 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= tccb_pkg::CFG_DRAW_COLOR;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_func      <= tccb_pkg::FUNC_PUT;
        s_char_code <= '0;
        s_read_row  <= '0;
        s_read_col  <= '0;
        errors        = 0;
        n_results     = 0;
        n_puts        = 0;
        n_reads       = 0;
        n_outside     = 0;
        n_scrolls     = 0;
        n_settings    = 1;
        send_idle_pct = 34;
        recv_idle_pct = 67;
        console_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_control_chars();
        test_register_cases();
        test_random_phase(130, CFG_DATA_W'($urandom_range(0, 6)),
                          CFG_DATA_W'($urandom_range(0, 255)), 8'd80);

        send_idle_pct = 67;
        recv_idle_pct = 34;
        test_random_phase(40, 8'd7, 8'd128, 8'd1);
        test_random_phase(90, CFG_DATA_W'($urandom_range(0, 255)),
                          CFG_DATA_W'($urandom_range(0, 255)), 8'd5);
        test_scroll_at_bottom();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(70, 8'd0, 8'd255, 8'd160);
        test_random_phase(70, CFG_DATA_W'($urandom_range(0, 7)),
                          CFG_DATA_W'($urandom_range(0, 255)), 8'd200);

        wait_results();
        repeat (END_SLACK) @(posedge aclk);
        $display("covered %0d puts with %0d scrolls and %0d reads (%0d off the grid)",
                 n_puts, n_scrolls, n_reads, n_outside);
        $display("over %0d register settings; %0d results checked, %0d mismatches",
                 n_settings, n_results, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("text_console_cell_buffer_top_test: done, clean");
        end else begin
            $display("text_console_cell_buffer_top_test: done, errors");
        end
        $finish;
    end

endmodule
